// File: design/abfc_pkg.sv
`default_nettype none
package abfc_pkg;

  localparam int WORD_BITS   = 32;
  localparam int MAX_BITS    = 4096;
  localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int POS_W       = $clog2(WORD_BITS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int CFG_W       = 13;
  localparam int IDX_W       = 12;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_FIND,
    S_EMIT
  } state_t;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage
`default_nettype wire

// File: design/abfc_ram.sv
`default_nettype none
module abfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/allocation_bitmap_first_clear_top.sv
// allocation bitmap with find-first-clear
//
// input channel (in_valid/in_ready) carries one request: in_cmd (read, set,
// clear, find first clear) and in_bit_index. every request gives exactly one
// result on the output channel (out_valid/out_ready): out_bit_value,
// out_found_index and out_status.
// cfg_write_en/cfg_write_data set the number of bits in use (whole words);
// write it only while no request is in flight.
// read takes one read of the word memory, set and clear take one
// read-modify-write of it; a rejected index skips the memory. the next
// request is taken in the cycle after the result is loaded, never before.
// find walks the per-word full flags, one word per cycle, then reads the
// first word with a clear bit.
// at reset all bits read clear through per-word valid flags; no clearing
// pass is needed and requests are taken right after reset.
// a finished result sits in the output register; the next request is taken
// while it waits, and that one stalls only at its own result stage.
`default_nettype none
module allocation_bitmap_first_clear_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [abfc_pkg::IDX_W-1:0]    in_bit_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_bit_value,
  output logic      [abfc_pkg::IDX_W-1:0]    out_found_index,
  output logic                               out_status,
  input  wire logic                          cfg_write_en,
  input  wire logic [abfc_pkg::CFG_W-1:0]    cfg_write_data
);
  import abfc_pkg::*;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]  widx_r, widx_nxt;
  logic [POS_W-1:0]   bpos_r, bpos_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]   words_r;
  logic [STORE_WORDS-1:0] valid_r, full_r;

  logic               res_value_r, res_value_nxt;
  logic [IDX_W-1:0]   res_found_r, res_found_nxt;
  logic               res_status_r, res_status_nxt;

  logic               out_valid_r;
  logic               out_value_r, out_status_r;
  logic [IDX_W-1:0]   out_found_r;
  logic               out_load;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  word_t              ram_wdata, ram_rdata;

  logic [CFG_W-1:0]   cfg_clamp;
  logic [CFG_W-1:0]   cfg_sum;

  abfc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // live word count, kept ready from the register write
  always_comb begin
    cfg_clamp = (cfg_write_data > CFG_W'(MAX_BITS)) ? CFG_W'(MAX_BITS) : cfg_write_data;
    cfg_sum   = cfg_clamp + CFG_W'(WORD_BITS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= CNT_W'(STORE_WORDS);
    end else if (cfg_write_en) begin
      words_r <= cfg_sum[POS_W +: CNT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    widx_r       <= widx_nxt;
    bpos_r       <= bpos_nxt;
    scan_r       <= scan_nxt;
    res_value_r  <= res_value_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
  end

  always_comb begin
    word_t            cur_word;
    word_t            new_word;
    logic [POS_W-1:0] clear_pos;
    logic [ADDR_W-1:0] in_widx;

    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    widx_nxt       = widx_r;
    bpos_nxt       = bpos_r;
    scan_nxt       = scan_r;
    res_value_nxt  = res_value_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    in_ready       = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = widx_r;
    ram_we         = 1'b0;
    out_load       = 1'b0;
    in_widx        = in_bit_index[POS_W +: ADDR_W];

    cur_word = valid_r[widx_r] ? ram_rdata : '0;
    new_word = cur_word;
    if (cmd_r == CMD_SET) begin
      new_word[~bpos_r] = 1'b1;
    end else begin
      new_word[~bpos_r] = 1'b0;
    end
    ram_wdata = new_word;

    // lowest index with a clear mark, msb first
    clear_pos = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (!cur_word[WORD_BITS-1-k]) begin
        clear_pos = POS_W'(k);
      end
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt        = cmd_t'(in_cmd);
          widx_nxt       = in_widx;
          bpos_nxt       = in_bit_index[POS_W-1:0];
          scan_nxt       = '0;
          res_value_nxt  = 1'b0;
          res_found_nxt  = '0;
          res_status_nxt = 1'b0;
          if (cmd_t'(in_cmd) == CMD_FIND) begin
            state_nxt = S_SCAN;
          end else if ({1'b0, in_widx} >= words_r) begin
            res_status_nxt = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = in_widx;
            state_nxt = S_ACCESS;
          end
        end
      end
      S_ACCESS: begin
        if (cmd_r == CMD_READ) begin
          res_value_nxt = cur_word[~bpos_r];
        end else begin
          ram_we = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (scan_r >= words_r) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_EMIT;
        end else if (!full_r[scan_r[ADDR_W-1:0]]) begin
          ram_re    = 1'b1;
          ram_raddr = scan_r[ADDR_W-1:0];
          widx_nxt  = scan_r[ADDR_W-1:0];
          state_nxt = S_FIND;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      S_FIND: begin
        res_found_nxt = IDX_W'({widx_r, clear_pos});
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // per-word valid and full flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      full_r  <= '0;
    end else if (ram_we) begin
      valid_r[widx_r] <= 1'b1;
      full_r[widx_r]  <= &ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_value   = out_value_r;
  assign out_found_index = out_found_r;
  assign out_status      = out_status_r;

  a_access_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCESS) |-> ({1'b0, widx_r} < words_r))
    else $error("word access beyond live words");

  a_find_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> !full_r[widx_r])
    else $error("find landed on a full word");

  a_write_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_ACCESS && (cmd_r == CMD_SET || cmd_r == CMD_CLEAR)))
    else $error("memory write outside set or clear");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ready) |=> (state_r == S_EMIT))
    else $error("result dropped while output stalled");

endmodule
`default_nettype wire
